/* src/hbcc_pkg.sv */
`default_nettype none

package hbcc_pkg;

  localparam int unsigned HallW      = 3;
  localparam int unsigned SpeedW     = 12;
  localparam int unsigned PatW       = 6;
  localparam int unsigned ThrW       = 12;
  localparam int unsigned ThrReset   = 240;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ResBufDepth = 4;

  localparam logic [ApbAddrW-3:0] RegSpeedThreshold = '0;

  typedef enum logic {
    CmdDirCheck = 1'b0,
    CmdCommutate = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [PatW-1:0] pattern;
    logic            bridge_valid;
    logic            trigger;
    logic            timer_on;
    logic            rst_sensor;
    logic            meas_dir;
    logic            last;
  } result_t;

  function automatic logic [HallW-1:0] succ_bwd(input logic [HallW-1:0] h);
    logic [HallW-1:0] r;
    case (h)
      3'd1: r = 3'd5;
      3'd2: r = 3'd3;
      3'd3: r = 3'd1;
      3'd4: r = 3'd6;
      3'd5: r = 3'd4;
      3'd6: r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [HallW-1:0] succ_fwd(input logic [HallW-1:0] h);
    logic [HallW-1:0] r;
    case (h)
      3'd1: r = 3'd3;
      3'd2: r = 3'd6;
      3'd3: r = 3'd2;
      3'd4: r = 3'd5;
      3'd5: r = 3'd1;
      3'd6: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PatW-1:0] pat_man_fwd(input logic [HallW-1:0] h);
    logic [PatW-1:0] r;
    case (h)
      3'd1: r = 6'd18;
      3'd2: r = 6'd9;
      3'd3: r = 6'd24;
      3'd4: r = 6'd36;
      3'd5: r = 6'd6;
      3'd6: r = 6'd33;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PatW-1:0] pat_man_bwd(input logic [HallW-1:0] h);
    logic [PatW-1:0] r;
    case (h)
      3'd1: r = 6'd9;
      3'd2: r = 6'd36;
      3'd3: r = 6'd33;
      3'd4: r = 6'd18;
      3'd5: r = 6'd24;
      3'd6: r = 6'd6;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PatW-1:0] pat_accel(input logic [HallW-1:0] h);
    logic [PatW-1:0] r;
    case (h)
      3'd1: r = 6'd24;
      3'd2: r = 6'd33;
      3'd3: r = 6'd9;
      3'd4: r = 6'd6;
      3'd5: r = 6'd18;
      3'd6: r = 6'd36;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/hall_bldc_commutation_control.sv */
// Each result beat passes through the input register and then the result buffer before
// it is offered on the output.
// Throughput: one input beat per cycle while the result buffer has room; an item that
// returns to timer mode emits two result beats and so occupies two output beats.
// Reset clears the control state: hall position 0, forward directions, manual mode on,
// speed threshold 240, and an empty result buffer (stored data words are not reset).
`default_nettype none

module hall_bldc_commutation_control #(
  parameter int unsigned ResBufDepth = hbcc_pkg::ResBufDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // hall_state [2:0], speed_abs [14:3], requested_direction [15]
  input  wire logic [hbcc_pkg::InDataW-1:0]    s_axis_tdata,
  // cmd [0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // bridge_pattern [5:0], trigger_event [6], timer_commutation_on [7],
  // reset_current_sensor [8], measured_direction [9], zeros [15:10]
  output logic [hbcc_pkg::OutDataW-1:0]        m_axis_tdata,
  // bridge_valid [0]
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hbcc_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [hbcc_pkg::ApbDataW-1:0]   pwdata,
  output logic [hbcc_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready
);

  localparam int unsigned PtrW = (ResBufDepth > 1) ? $clog2(ResBufDepth) : 1;
  localparam int unsigned CntW = $clog2(ResBufDepth + 1);
  localparam logic [CntW-1:0] FireLimit = CntW'(ResBufDepth - 2);

  // Configuration register.
  logic [hbcc_pkg::ThrW-1:0] thr_q;
  logic                      reg_sel;
  assign reg_sel = (paddr[hbcc_pkg::ApbAddrW-1:2] == hbcc_pkg::RegSpeedThreshold);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hbcc_pkg::ThrW'(hbcc_pkg::ThrReset);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      thr_q <= pwdata[hbcc_pkg::ThrW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[hbcc_pkg::ThrW-1:0] = thr_q;
    end
  end

  // Input register.
  logic                        in_valid_q;
  hbcc_pkg::cmd_e              cmd_q;
  logic [hbcc_pkg::HallW-1:0]  hall_q;
  logic [hbcc_pkg::SpeedW-1:0] speed_q;
  logic                        req_q;
  logic                        fire;
  logic [CntW-1:0]             count_q;

  assign fire          = in_valid_q && (count_q <= FireLimit);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q   <= hbcc_pkg::cmd_e'(s_axis_tuser);
      hall_q  <= s_axis_tdata[2:0];
      speed_q <= s_axis_tdata[14:3];
      req_q   <= s_axis_tdata[15];
    end
  end

  // Commutation state and result computation.
  logic [hbcc_pkg::HallW-1:0] last_hall_q, last_hall_d;
  logic meas_q, meas_d;
  logic applied_q, applied_d;
  logic manual_q, manual_d;
  hbcc_pkg::result_t res0, res1;
  logic two_res;
  logic [hbcc_pkg::HallW-1:0] prev_pos;
  logic [hbcc_pkg::PatW-1:0]  man_pat;
  logic rst_sensor;

  always_comb begin
    last_hall_d = last_hall_q;
    meas_d      = meas_q;
    applied_d   = applied_q;
    manual_d    = manual_q;
    two_res     = 1'b0;
    prev_pos    = meas_q ? hbcc_pkg::succ_fwd(hall_q) : hbcc_pkg::succ_bwd(hall_q);
    rst_sensor  = (req_q != applied_q);
    man_pat     = req_q ? hbcc_pkg::pat_man_bwd(hall_q) : hbcc_pkg::pat_man_fwd(hall_q);
    res0        = '0;
    res1        = '0;
    case (cmd_q)
      hbcc_pkg::CmdDirCheck: begin
        if (prev_pos != last_hall_q) begin
          meas_d = (hbcc_pkg::succ_bwd(last_hall_q) == hall_q);
        end
        last_hall_d       = hall_q;
        res0.timer_on     = !manual_q;
        res0.meas_dir     = meas_d;
        res0.last         = 1'b1;
      end
      hbcc_pkg::CmdCommutate: begin
        applied_d         = req_q;
        res0.bridge_valid = 1'b1;
        res0.rst_sensor   = rst_sensor;
        res0.meas_dir     = meas_q;
        if (manual_q && (req_q == meas_q) && (speed_q > thr_q)) begin
          two_res           = 1'b1;
          manual_d          = 1'b0;
          res0.pattern      = man_pat;
          res0.trigger      = 1'b1;
          res1.pattern      = hbcc_pkg::pat_accel(hall_q);
          res1.bridge_valid = 1'b1;
          res1.timer_on     = 1'b1;
          res1.meas_dir     = meas_q;
          res1.last         = 1'b1;
        end else begin
          if (!manual_q && (req_q != meas_q)) begin
            manual_d = 1'b1;
          end
          res0.last = 1'b1;
          if (manual_d) begin
            res0.pattern = man_pat;
            res0.trigger = 1'b1;
          end else begin
            res0.pattern  = hbcc_pkg::pat_accel(hall_q);
            res0.timer_on = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hall_q <= '0;
      meas_q      <= 1'b0;
      applied_q   <= 1'b0;
      manual_q    <= 1'b1;
    end else if (fire) begin
      last_hall_q <= last_hall_d;
      meas_q      <= meas_d;
      applied_q   <= applied_d;
      manual_q    <= manual_d;
    end
  end

  // Result buffer.
  hbcc_pkg::result_t buf_q [ResBufDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic            pop;
  logic [CntW-1:0] n_push;

  assign pop       = m_axis_tvalid && m_axis_tready;
  assign n_push    = fire ? (two_res ? CntW'(2) : CntW'(1)) : '0;
  assign wr_ptr_nx = PtrW'((wr_ptr_q + 1'b1) % ResBufDepth);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      buf_q[wr_ptr_q] <= res0;
      if (two_res) begin
        buf_q[wr_ptr_nx] <= res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= PtrW'((wr_ptr_q + n_push) % ResBufDepth);
      if (pop) begin
        rd_ptr_q <= PtrW'((rd_ptr_q + 1'b1) % ResBufDepth);
      end
      count_q <= count_q + n_push - CntW'(pop);
    end
  end

  hbcc_pkg::result_t head;
  assign head          = buf_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tuser  = head.bridge_valid;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {6'b0, head.meas_dir, head.rst_sensor, head.timer_on,
                          head.trigger, head.pattern};

endmodule

`default_nettype wire

/* sim/hall_bldc_commutation_control_test.sv */
`timescale 1ns / 100ps

module hall_bldc_commutation_control_test;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned BlockItems = 240;

  // Next hall code for each code, indexed by code; codes 0 and 7 map to 0.
  localparam logic [7:0][2:0] HallBackNext = {3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd0};
  localparam logic [7:0][2:0] HallFwdNext = {3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd0};
  localparam logic [7:0][5:0] ManFwdPat =
    {6'd0, 6'd33, 6'd6, 6'd36, 6'd24, 6'd9, 6'd18, 6'd0};
  localparam logic [7:0][5:0] ManBwdPat =
    {6'd0, 6'd6, 6'd24, 6'd18, 6'd33, 6'd36, 6'd9, 6'd0};
  localparam logic [7:0][5:0] AccelPat =
    {6'd0, 6'd36, 6'd18, 6'd6, 6'd9, 6'd33, 6'd24, 6'd0};

  typedef struct packed {
    logic [5:0] pattern;
    logic       bridge_valid;
    logic       trigger;
    logic       timer_on;
    logic       rst_sensor;
    logic       meas_dir;
    logic       last_beat;
  } bridge_beat_t;

  class commutation_scoreboard;
    bridge_beat_t due_q[$];
    int unsigned failures;
    logic [11:0] threshold;
    logic [2:0] last_hall;
    logic meas_dir;
    logic applied_dir;
    logic manual_on;

    function new();
      failures = 0;
      threshold = 12'(hbcc_pkg::ThrReset);
      last_hall = '0;
      meas_dir = 1'b0;
      applied_dir = 1'b0;
      manual_on = 1'b1;
    endfunction

    function void set_threshold(logic [11:0] value);
      threshold = value;
    endfunction

    function void flag(string msg);
      if (failures < 10) begin
        $display("%0t: %s", $realtime, msg);
      end
      failures++;
    endfunction

    function string show(bridge_beat_t b);
      return $sformatf("pattern=%0d valid=%b trig=%b timer=%b rst=%b dir=%b last=%b",
                       b.pattern, b.bridge_valid, b.trigger, b.timer_on, b.rst_sensor,
                       b.meas_dir, b.last_beat);
    endfunction

    function void push_beat(logic [5:0] pattern, logic valid, logic trig, logic timer_on,
                            logic rst, logic last_beat);
      bridge_beat_t b;
      b.pattern = pattern;
      b.bridge_valid = valid;
      b.trigger = trig;
      b.timer_on = timer_on;
      b.rst_sensor = rst;
      b.meas_dir = meas_dir;
      b.last_beat = last_beat;
      due_q.push_back(b);
    endfunction

    function logic [5:0] manual_pattern(logic [2:0] hall);
      return applied_dir ? ManBwdPat[hall] : ManFwdPat[hall];
    endfunction

    function void note_item(hbcc_pkg::cmd_e cmd, logic [2:0] hall, logic [11:0] speed,
                            logic req);
      logic [2:0] prev;
      logic rst;
      if (cmd == hbcc_pkg::CmdDirCheck) begin
        prev = meas_dir ? HallFwdNext[hall] : HallBackNext[hall];
        if (prev != last_hall) begin
          meas_dir = (HallBackNext[last_hall] == hall);
        end
        last_hall = hall;
        push_beat(6'd0, 1'b0, 1'b0, !manual_on, 1'b0, 1'b1);
        return;
      end
      rst = (req != applied_dir);
      applied_dir = req;
      if (manual_on && applied_dir == meas_dir && speed > threshold) begin
        push_beat(manual_pattern(hall), 1'b1, 1'b1, 1'b0, rst, 1'b0);
        manual_on = 1'b0;
        push_beat(AccelPat[hall], 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        return;
      end
      if (!manual_on && applied_dir != meas_dir) begin
        manual_on = 1'b1;
      end
      if (manual_on) begin
        push_beat(manual_pattern(hall), 1'b1, 1'b1, 1'b0, rst, 1'b1);
      end else begin
        push_beat(AccelPat[hall], 1'b1, 1'b0, 1'b1, rst, 1'b1);
      end
    endfunction

    function void check_beat(logic [hbcc_pkg::OutDataW-1:0] data, logic user, logic last_bit);
      bridge_beat_t got;
      bridge_beat_t want;
      got.pattern = data[5:0];
      got.bridge_valid = user;
      got.trigger = data[6];
      got.timer_on = data[7];
      got.rst_sensor = data[8];
      got.meas_dir = data[9];
      got.last_beat = last_bit;
      if (due_q.size() == 0) begin
        flag({"unexpected beat: ", show(got)});
        return;
      end
      want = due_q.pop_front();
      if (got !== want) begin
        flag({"mismatch: expected ", show(want), " actual ", show(got)});
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [hbcc_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [hbcc_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [hbcc_pkg::ApbAddrW-1:0] paddr = '0;
  logic [hbcc_pkg::ApbDataW-1:0] pwdata = '0;
  logic [hbcc_pkg::ApbDataW-1:0] prdata;
  logic pready;

  commutation_scoreboard sb;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [2:0] motor_hall = 3'd1;
  logic motor_dir = 1'b0;

  hall_bldc_commutation_control uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_item(hbcc_pkg::cmd_e'(s_axis_tuser), s_axis_tdata[2:0],
                   s_axis_tdata[14:3], s_axis_tdata[15]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(hbcc_pkg::cmd_e cmd, logic [2:0] hall, logic [11:0] speed,
                           logic req);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {req, speed, hall};
    s_axis_tuser <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_speed_threshold(logic [11:0] value);
    logic [hbcc_pkg::ApbDataW-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {hbcc_pkg::RegSpeedThreshold, 2'b00};
    pwdata <= hbcc_pkg::ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    sb.set_threshold(value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== hbcc_pkg::ApbDataW'(value)) begin
      sb.flag($sformatf("threshold read back %0d, expected %0d", rd, value));
    end
  endtask

  task automatic run_block(int unsigned count, logic [11:0] thr, bit with_hold);
    hbcc_pkg::cmd_e cmd;
    logic [2:0] hall;
    logic [11:0] speed;
    logic req;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_drained();
      end
      if (with_hold && i == 30) begin
        hold_ask <= hold_ask + 1;
      end
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 60) begin
          if ($urandom_range(99) < 6) begin
            motor_dir = ~motor_dir;
          end
          motor_hall = motor_dir ? HallBackNext[motor_hall] : HallFwdNext[motor_hall];
          cmd = hbcc_pkg::CmdDirCheck;
          req = 1'($urandom_range(1));
        end else begin
          cmd = hbcc_pkg::CmdCommutate;
          req = ($urandom_range(99) < 80) ? motor_dir : ~motor_dir;
        end
        hall = motor_hall;
        case ($urandom_range(5))
          0: speed = 12'd0;
          1: speed = 12'd4095;
          2: speed = thr;
          3: speed = thr + 12'd1;
          4: speed = (thr == 0) ? 12'd0 : thr - 12'd1;
          default: speed = 12'($urandom_range(4095));
        endcase
      end else begin
        cmd = hbcc_pkg::cmd_e'($urandom_range(1));
        hall = 3'($urandom_range(7));
        speed = 12'($urandom_range(4095));
        req = 1'($urandom_range(1));
      end
      send_item(cmd, hall, speed, req);
    end
  endtask

  initial begin
    logic [11:0] thr_list [6];
    sb = new();
    thr_list[0] = 12'd0;
    thr_list[1] = 12'd4095;
    thr_list[2] = 12'd240;
    thr_list[3] = 12'($urandom_range(4095));
    thr_list[4] = 12'd1;
    thr_list[5] = 12'($urandom_range(4095));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_speed_threshold(12'd240);

    send_item(hbcc_pkg::CmdDirCheck, 3'd0, 12'd0, 1'b0);
    send_item(hbcc_pkg::CmdDirCheck, 3'd7, 12'd4095, 1'b1);
    send_item(hbcc_pkg::CmdDirCheck, 3'd0, 12'd0, 1'b0);
    send_item(hbcc_pkg::CmdCommutate, 3'd0, 12'd0, 1'b0);
    send_item(hbcc_pkg::CmdCommutate, 3'd7, 12'd4095, 1'b0);
    send_item(hbcc_pkg::CmdDirCheck, 3'd1, 12'd50, 1'b1);
    send_item(hbcc_pkg::CmdDirCheck, 3'd3, 12'd60, 1'b1);
    send_item(hbcc_pkg::CmdDirCheck, 3'd2, 12'd70, 1'b0);
    send_item(hbcc_pkg::CmdDirCheck, 3'd6, 12'd80, 1'b1);
    send_item(hbcc_pkg::CmdDirCheck, 3'd4, 12'd90, 1'b0);
    send_item(hbcc_pkg::CmdDirCheck, 3'd5, 12'd95, 1'b1);
    send_item(hbcc_pkg::CmdCommutate, 3'd5, 12'd100, 1'b0);
    send_item(hbcc_pkg::CmdCommutate, 3'd5, 12'd4095, 1'b1);
    send_item(hbcc_pkg::CmdDirCheck, 3'd4, 12'd300, 1'b1);
    send_item(hbcc_pkg::CmdDirCheck, 3'd6, 12'd300, 1'b1);
    send_item(hbcc_pkg::CmdCommutate, 3'd6, 12'd241, 1'b1);
    send_item(hbcc_pkg::CmdCommutate, 3'd6, 12'd240, 1'b1);
    send_item(hbcc_pkg::CmdCommutate, 3'd2, 12'd0, 1'b0);
    send_item(hbcc_pkg::CmdDirCheck, 3'd5, 12'd10, 1'b0);
    send_item(hbcc_pkg::CmdCommutate, 3'd5, 12'd240, 1'b0);
    send_item(hbcc_pkg::CmdCommutate, 3'd5, 12'd241, 1'b0);
    wait_drained();

    for (int b = 0; b < 6; b++) begin
      if (b < 2) begin
        send_idle = 36;
        recv_idle <= 71;
      end else if (b < 4) begin
        send_idle = 71;
        recv_idle <= 36;
      end else begin
        send_idle = 0;
        recv_idle <= 0;
      end
      wait_drained();
      set_speed_threshold(thr_list[b]);
      run_block(BlockItems, thr_list[b], b == 4);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
src/hbcc_pkg.sv
src/hall_bldc_commutation_control.sv
sim/hall_bldc_commutation_control_test.sv
